// ===== src/assert_macros.svh =====
// Assertion macros used by the checker file.
// No dependencies; each macro expects clk and rst_n in scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define KTS_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("kts assertion failed");

// Next-cycle implication, disabled during reset.
`define KTS_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("kts assertion failed");

`endif

// ===== src/kts_pkg.sv =====
// Shared types and codes of the triple scorer.
// No dependencies; used by controller, datapath, top level and checker.
package kts_pkg;

    localparam logic [1:0] OP_ENT   = 2'd0;
    localparam logic [1:0] OP_REL   = 2'd1;
    localparam logic [1:0] OP_QUAT  = 2'd2;
    localparam logic [1:0] OP_SCORE = 2'd3;

    localparam logic [1:0] REG_DIM  = 2'd0;
    localparam logic [1:0] REG_MODE = 2'd1;

    localparam logic [1:0] MODE_TRANS  = 2'd0;
    localparam logic [1:0] MODE_QUAT   = 2'd1;
    localparam logic [1:0] MODE_HYBRID = 2'd2;
    localparam logic [1:0] MODE_UNUSED = 2'd3;

    localparam logic [1:0] RD_HEAD = 2'd0;
    localparam logic [1:0] RD_REL  = 2'd1;
    localparam logic [1:0] RD_TAIL = 2'd2;

    localparam logic [15:0] SCORE_MAX = 16'hFFFF;
    localparam logic [6:0]  DIM_RESET = 7'd64;

    typedef struct packed {
        logic       ready;
        logic       load;
        logic [1:0] rd_sel;
        logic       cap_h;
        logic       cap_r;
        logic       cap_t;
        logic       mul;
        logic       sum;
        logic       sqr;
        logic       root_go;
        logic       root_q;
        logic       save_t;
        logic       save_q;
        logic       out_load;
    } kts_cmd_t;

    typedef struct packed {
        logic bad;
        logic last_comp;
        logic last_dim;
        logic root_done;
        logic out_busy;
    } kts_stat_t;

endpackage

// ===== src/kts_ram.sv =====
// Generic single-port RAM with registered read data.
// No dependencies; instanced for every embedding store.
module kts_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 1024
) (
    input  logic                                       clk,
    input  logic                                       we,
    input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] addr,
    input  logic [WIDTH-1:0]                           wdata,
    output logic [WIDTH-1:0]                           rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[addr] <= wdata;
        end
        rdata_reg <= mem_reg[addr];
    end

    assign rdata = rdata_reg;

endmodule

// ===== src/kts_root.sv =====
// Iterative unit: floor division by the dimension, then integer square root.
// No dependencies; one quotient bit, then one root bit per cycle.
module kts_root #(
    parameter int ACC_W = 54,
    parameter int DW    = 7
) (
    input  logic                     clk,
    input  logic                     rst_n,
    input  logic                     start,
    input  logic [ACC_W-1:0]         num,
    input  logic [DW-1:0]            den,
    output logic                     done,
    output logic [(ACC_W+1)/2-1:0]   root
);

    localparam int SQ_W = (ACC_W + 1) / 2;
    localparam int CW   = $clog2(ACC_W + 1);

    logic            busy_reg, busy_next;
    logic            sq_reg, sq_next;
    logic            done_reg, done_next;
    logic [CW-1:0]   cnt_reg, cnt_next;
    logic [ACC_W-1:0] quo_reg, quo_next;
    logic [DW-1:0]   rem_reg, rem_next;
    logic [DW-1:0]   den_reg, den_next;
    logic [2*SQ_W-1:0] val_reg, val_next;
    logic [SQ_W:0]   srem_reg, srem_next;
    logic [SQ_W-1:0] root_reg, root_next;

    logic [DW:0]     dtrial;
    logic [SQ_W+2:0] strial, sacc;
    logic [ACC_W-1:0] quo_step;

    always_comb
    begin
        dtrial    = {rem_reg, quo_reg[ACC_W-1]};
        sacc      = {srem_reg, val_reg[2*SQ_W-1 -: 2]};
        strial    = {1'b0, root_reg, 2'b01};
        quo_step  = {quo_reg[ACC_W-2:0], 1'b0};
        busy_next = busy_reg;
        sq_next   = sq_reg;
        done_next = 1'b0;
        cnt_next  = cnt_reg;
        quo_next  = quo_reg;
        rem_next  = rem_reg;
        den_next  = den_reg;
        val_next  = val_reg;
        srem_next = srem_reg;
        root_next = root_reg;
        if (start)
        begin
            busy_next = 1'b1;
            sq_next   = 1'b0;
            cnt_next  = CW'(ACC_W);
            quo_next  = num;
            rem_next  = '0;
            den_next  = den;
        end
        else if (busy_reg && !sq_reg)
        begin
            if (dtrial >= {1'b0, den_reg})
            begin
                rem_next = DW'(dtrial - {1'b0, den_reg});
                quo_next = quo_step | ACC_W'(1);
            end
            else
            begin
                rem_next = dtrial[DW-1:0];
                quo_next = quo_step;
            end
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                sq_next   = 1'b1;
                cnt_next  = CW'(SQ_W);
                val_next  = (2*SQ_W)'(quo_next);
                srem_next = '0;
                root_next = '0;
            end
        end
        else if (busy_reg)
        begin
            if (sacc >= strial)
            begin
                srem_next = (SQ_W+1)'(sacc - strial);
                root_next = {root_reg[SQ_W-2:0], 1'b1};
            end
            else
            begin
                srem_next = sacc[SQ_W:0];
                root_next = {root_reg[SQ_W-2:0], 1'b0};
            end
            val_next = {val_reg[2*SQ_W-3:0], 2'b00};
            cnt_next = cnt_reg - CW'(1);
            if (cnt_reg == CW'(1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            sq_reg   <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            sq_reg   <= sq_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        quo_reg  <= quo_next;
        rem_reg  <= rem_next;
        den_reg  <= den_next;
        val_reg  <= val_next;
        srem_reg <= srem_next;
        root_reg <= root_next;
    end

    assign done = done_reg;
    assign root = root_reg;

endmodule

// ===== src/kts_ctrl.sv =====
// Sequencer of the triple scorer: reads, products, accumulation, root, output.
// Depends on kts_pkg.
module kts_ctrl (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                s_tvalid,
    input  logic [1:0]          s_tuser,
    input  kts_pkg::kts_stat_t  stat,
    output kts_pkg::kts_cmd_t   cmd
);

    import kts_pkg::*;

    typedef enum logic [13:0] {
        S_IDLE   = 14'b00000000000001,
        S_CHECK  = 14'b00000000000010,
        S_RD_H   = 14'b00000000000100,
        S_RD_R   = 14'b00000000001000,
        S_RD_T   = 14'b00000000010000,
        S_CAP    = 14'b00000000100000,
        S_MUL    = 14'b00000001000000,
        S_SUM    = 14'b00000010000000,
        S_SQR    = 14'b00000100000000,
        S_ROOT_T = 14'b00001000000000,
        S_WAIT_T = 14'b00010000000000,
        S_ROOT_Q = 14'b00100000000000,
        S_WAIT_Q = 14'b01000000000000,
        S_FIN    = 14'b10000000000000
    } state_t;

    state_t state_reg, state_next;

    always_comb
    begin
        state_next = state_reg;
        cmd        = '0;
        cmd.rd_sel = RD_HEAD;
        case (state_reg)
            S_IDLE:
            begin
                cmd.ready = 1'b1;
                if (s_tvalid && s_tuser == OP_SCORE)
                begin
                    cmd.load   = 1'b1;
                    state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                state_next = stat.bad ? S_FIN : S_RD_H;
            end
            S_RD_H:
            begin
                cmd.rd_sel = RD_HEAD;
                state_next = S_RD_R;
            end
            S_RD_R:
            begin
                cmd.rd_sel = RD_REL;
                cmd.cap_h  = 1'b1;
                state_next = S_RD_T;
            end
            S_RD_T:
            begin
                cmd.rd_sel = RD_TAIL;
                cmd.cap_r  = 1'b1;
                state_next = S_CAP;
            end
            S_CAP:
            begin
                cmd.cap_t  = 1'b1;
                state_next = S_MUL;
            end
            S_MUL:
            begin
                cmd.mul    = 1'b1;
                state_next = S_SUM;
            end
            S_SUM:
            begin
                cmd.sum    = 1'b1;
                state_next = S_SQR;
            end
            S_SQR:
            begin
                cmd.sqr = 1'b1;
                if (!stat.last_comp)
                begin
                    state_next = S_MUL;
                end
                else if (stat.last_dim)
                begin
                    state_next = S_ROOT_T;
                end
                else
                begin
                    state_next = S_RD_H;
                end
            end
            S_ROOT_T:
            begin
                cmd.root_go = 1'b1;
                state_next  = S_WAIT_T;
            end
            S_WAIT_T:
            begin
                if (stat.root_done)
                begin
                    cmd.save_t = 1'b1;
                    state_next = S_ROOT_Q;
                end
            end
            S_ROOT_Q:
            begin
                cmd.root_go = 1'b1;
                cmd.root_q  = 1'b1;
                state_next  = S_WAIT_Q;
            end
            S_WAIT_Q:
            begin
                cmd.root_q = 1'b1;
                if (stat.root_done)
                begin
                    cmd.save_q = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                // hold the result until the output register frees up
                if (!stat.out_busy)
                begin
                    cmd.out_load = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== src/kts_dp.sv =====
// Datapath of the triple scorer: stores, products, accumulators, output register.
// Depends on kts_pkg, kts_ram and kts_root.
module kts_dp #(
    parameter int ENTITY_ROWS   = 1024,
    parameter int RELATION_ROWS = 256,
    parameter int DIM_MAX       = 64
) (
    input  logic               clk,
    input  logic               rst_n,
    input  kts_pkg::kts_cmd_t  cmd,
    output kts_pkg::kts_stat_t stat,
    input  logic               s_tvalid,
    input  logic [111:0]       s_tdata,
    input  logic [1:0]         s_tuser,
    output logic               m_tvalid,
    input  logic               m_tready,
    output logic [15:0]        m_tdata,
    output logic               m_tuser,
    input  logic               cfg_valid,
    input  logic [1:0]         cfg_index,
    input  logic [6:0]         cfg_data
);

    import kts_pkg::*;

    localparam int EDEPTH = ENTITY_ROWS * DIM_MAX;
    localparam int RDEPTH = RELATION_ROWS * DIM_MAX;
    localparam int EA_W   = EDEPTH > 1 ? $clog2(EDEPTH) : 1;
    localparam int RA_W   = RDEPTH > 1 ? $clog2(RDEPTH) : 1;
    localparam int DW     = $clog2(DIM_MAX + 1);
    localparam int ACC_W  = 48 + $clog2(DIM_MAX);
    localparam int SQ_W   = (ACC_W + 1) / 2;

    // input fields
    logic [9:0]  in_row, in_head, in_tail;
    logic [5:0]  in_elem;
    logic [7:0]  in_rel;
    logic [63:0] in_quat;
    logic        accept;

    assign in_row  = s_tdata[9:0];
    assign in_elem = s_tdata[15:10];
    assign in_quat = s_tdata[79:16];
    assign in_head = s_tdata[89:80];
    assign in_rel  = s_tdata[97:90];
    assign in_tail = s_tdata[107:98];
    assign accept  = s_tvalid && cmd.ready;

    // configuration registers
    logic [6:0] dim_cfg_reg;
    logic [1:0] mode_cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            dim_cfg_reg  <= DIM_RESET;
            mode_cfg_reg <= MODE_TRANS;
        end
        else if (cfg_valid)
        begin
            if (cfg_index == REG_DIM)
            begin
                dim_cfg_reg <= cfg_data;
            end
            else if (cfg_index == REG_MODE)
            begin
                mode_cfg_reg <= cfg_data[1:0];
            end
        end
    end

    logic [1:0]    mode_eff;
    logic [DW-1:0] dim_eff;
    logic          bad_in;

    always_comb
    begin
        mode_eff = (mode_cfg_reg == MODE_UNUSED) ? MODE_TRANS : mode_cfg_reg;
        if (dim_cfg_reg == 7'd0 || 32'(dim_cfg_reg) > 32'(DIM_MAX))
        begin
            dim_eff = DW'(DIM_MAX);
        end
        else
        begin
            dim_eff = DW'(dim_cfg_reg);
        end
        bad_in = 32'(in_head) >= 32'(ENTITY_ROWS) || 32'(in_tail) >= 32'(ENTITY_ROWS)
              || 32'(in_rel) >= 32'(RELATION_ROWS)
              || (mode_eff != MODE_TRANS && 32'(in_rel) >= 32'(ENTITY_ROWS));
    end

    // per-score context
    logic [9:0]    head_reg, tail_reg;
    logic [7:0]    rel_reg;
    logic [1:0]    mode_reg;
    logic [DW-1:0] dim_reg, d_reg;
    logic [1:0]    k_reg;
    logic          bad_reg;

    // store access
    logic        ent_in_rng, rel_in_rng;
    logic        we_ent, we_rel, we_quat;
    logic [31:0] wr_base, rd_base, rel_base;
    logic [9:0]  rd_row;
    logic [15:0] ent_rdata, rel_rdata;
    logic [63:0] quat_rdata;
    logic [EA_W-1:0] ent_addr;
    logic [RA_W-1:0] rel_addr;

    always_comb
    begin
        ent_in_rng = 32'(in_row) < 32'(ENTITY_ROWS) && 32'(in_elem) < 32'(DIM_MAX);
        rel_in_rng = 32'(in_row) < 32'(RELATION_ROWS) && 32'(in_elem) < 32'(DIM_MAX);
        we_ent  = accept && s_tuser == OP_ENT && ent_in_rng;
        we_rel  = accept && s_tuser == OP_REL && rel_in_rng;
        we_quat = accept && s_tuser == OP_QUAT && ent_in_rng;
        case (cmd.rd_sel)
            RD_HEAD: rd_row = head_reg;
            RD_REL:  rd_row = {2'b00, rel_reg};
            RD_TAIL: rd_row = tail_reg;
            default: rd_row = head_reg;
        endcase
        wr_base  = 32'(in_row) * 32'(DIM_MAX) + 32'(in_elem);
        rd_base  = 32'(rd_row) * 32'(DIM_MAX) + 32'(d_reg);
        rel_base = 32'(rel_reg) * 32'(DIM_MAX) + 32'(d_reg);
        ent_addr = (we_ent || we_quat) ? wr_base[EA_W-1:0] : rd_base[EA_W-1:0];
        rel_addr = we_rel ? wr_base[RA_W-1:0] : rel_base[RA_W-1:0];
    end

    kts_ram #(.WIDTH(16), .DEPTH(EDEPTH)) u_ent_ram (
        .clk   (clk),
        .we    (we_ent),
        .addr  (ent_addr),
        .wdata (in_quat[15:0]),
        .rdata (ent_rdata)
    );

    kts_ram #(.WIDTH(16), .DEPTH(RDEPTH)) u_rel_ram (
        .clk   (clk),
        .we    (we_rel),
        .addr  (rel_addr),
        .wdata (in_quat[15:0]),
        .rdata (rel_rdata)
    );

    kts_ram #(.WIDTH(64), .DEPTH(EDEPTH)) u_quat_ram (
        .clk   (clk),
        .we    (we_quat),
        .addr  (ent_addr),
        .wdata (in_quat),
        .rdata (quat_rdata)
    );

    // captured operands
    logic signed [15:0] hv_reg, rv_reg;
    logic signed [15:0] hq_reg [4];
    logic signed [15:0] rq_reg [4];
    logic signed [15:0] tq_reg [4];
    logic signed [17:0] tdiff_reg;
    logic signed [31:0] prod_reg [4];
    logic signed [22:0] qdiff_reg;
    logic [ACC_W-1:0]   acc_t_reg, acc_q_reg;
    logic [SQ_W-1:0]    st_reg, sq_reg;

    // shared divide and square-root unit
    logic [ACC_W-1:0] root_num;
    logic [SQ_W-1:0]  root_res;
    logic             root_done;

    // operand routing of the Hamilton product, one component per pass
    logic [1:0]         sel_a [4];
    logic [1:0]         sel_b [4];
    logic               neg   [4];
    logic signed [31:0] prod_next [4];
    logic signed [33:0] psum;
    logic signed [21:0] comp;
    logic signed [35:0] tsq;
    logic signed [45:0] qsq;

    always_comb
    begin
        for (int i = 0; i < 4; i++)
        begin
            sel_a[i] = 2'(i);
        end
        case (k_reg)
            2'd0:
            begin
                sel_b = '{2'd0, 2'd1, 2'd2, 2'd3};
                neg   = '{1'b0, 1'b1, 1'b1, 1'b1};
            end
            2'd1:
            begin
                sel_b = '{2'd1, 2'd0, 2'd3, 2'd2};
                neg   = '{1'b0, 1'b0, 1'b0, 1'b1};
            end
            2'd2:
            begin
                sel_b = '{2'd2, 2'd3, 2'd0, 2'd1};
                neg   = '{1'b0, 1'b1, 1'b0, 1'b0};
            end
            default:
            begin
                sel_b = '{2'd3, 2'd2, 2'd1, 2'd0};
                neg   = '{1'b0, 1'b0, 1'b1, 1'b0};
            end
        endcase
        for (int i = 0; i < 4; i++)
        begin
            prod_next[i] = hq_reg[sel_a[i]] * rq_reg[sel_b[i]];
            if (neg[i])
            begin
                prod_next[i] = -prod_next[i];
            end
        end
        psum = 34'(prod_reg[0]) + 34'(prod_reg[1]) + 34'(prod_reg[2]) + 34'(prod_reg[3]);
        comp = psum[33:12];
        tsq  = tdiff_reg * tdiff_reg;
        qsq  = qdiff_reg * qdiff_reg;
    end

    always_ff @(posedge clk)
    begin
        if (cmd.load)
        begin
            head_reg <= in_head;
            tail_reg <= in_tail;
            rel_reg  <= in_rel;
            mode_reg <= mode_eff;
            dim_reg  <= dim_eff;
            bad_reg  <= bad_in;
            d_reg    <= '0;
            k_reg    <= '0;
            acc_t_reg <= '0;
            acc_q_reg <= '0;
        end
        if (cmd.cap_h)
        begin
            hv_reg <= ent_rdata;
            for (int i = 0; i < 4; i++)
            begin
                hq_reg[i] <= quat_rdata[16*i +: 16];
            end
        end
        if (cmd.cap_r)
        begin
            rv_reg <= rel_rdata;
            for (int i = 0; i < 4; i++)
            begin
                rq_reg[i] <= quat_rdata[16*i +: 16];
            end
        end
        if (cmd.cap_t)
        begin
            tdiff_reg <= 18'(hv_reg) + 18'(rv_reg) - 18'($signed(ent_rdata));
            for (int i = 0; i < 4; i++)
            begin
                tq_reg[i] <= quat_rdata[16*i +: 16];
            end
        end
        if (cmd.mul)
        begin
            prod_reg <= prod_next;
            if (k_reg == 2'd0)
            begin
                acc_t_reg <= acc_t_reg + ACC_W'(unsigned'(tsq));
            end
        end
        if (cmd.sum)
        begin
            qdiff_reg <= 23'(comp) - 23'(tq_reg[k_reg]);
        end
        if (cmd.sqr)
        begin
            acc_q_reg <= acc_q_reg + ACC_W'(unsigned'(qsq));
            k_reg     <= k_reg + 2'd1;
            if (k_reg == 2'd3)
            begin
                d_reg <= d_reg + DW'(1);
            end
        end
        if (cmd.save_t)
        begin
            st_reg <= root_res;
        end
        if (cmd.save_q)
        begin
            sq_reg <= root_res;
        end
    end

    assign root_num = cmd.root_q ? (acc_q_reg >> 2) : acc_t_reg;

    kts_root #(.ACC_W(ACC_W), .DW(DW)) u_root (
        .clk   (clk),
        .rst_n (rst_n),
        .start (cmd.root_go),
        .num   (root_num),
        .den   (dim_reg),
        .done  (root_done),
        .root  (root_res)
    );

    // result selection and output register
    logic [SQ_W:0]  avg;
    logic [SQ_W-1:0] pick;
    logic [15:0]    score_next;

    always_comb
    begin
        avg = ({1'b0, st_reg} + {1'b0, sq_reg}) >> 1;
        case (mode_reg)
            MODE_QUAT:   pick = sq_reg;
            MODE_HYBRID: pick = avg[SQ_W-1:0];
            default:     pick = st_reg;
        endcase
        if (bad_reg || 32'(pick) > 32'(SCORE_MAX))
        begin
            score_next = SCORE_MAX;
        end
        else
        begin
            score_next = pick[15:0];
        end
    end

    logic        out_valid_reg;
    logic [15:0] out_score_reg;
    logic        out_oor_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (cmd.out_load)
        begin
            out_valid_reg <= 1'b1;
        end
        else if (m_tready)
        begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.out_load)
        begin
            out_score_reg <= score_next;
            out_oor_reg   <= bad_reg;
        end
    end

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = out_score_reg;
    assign m_tuser  = out_oor_reg;

    assign stat.bad       = bad_reg;
    assign stat.last_comp = (k_reg == 2'd3);
    assign stat.last_dim  = (d_reg == dim_reg - DW'(1));
    assign stat.root_done = root_done;
    assign stat.out_busy  = out_valid_reg && !m_tready;

endmodule

// ===== src/knowledge_triple_scorer_top.sv =====
// Top level of the triple scorer: stream ports, configuration port.
// Depends on kts_pkg, kts_ctrl and kts_dp.
//
//  channel  direction  handshake             payload
//  s_       in         s_tvalid / s_tready   s_tdata, s_tuser (op)
//  m_       out        m_tvalid / m_tready   m_tdata (score), m_tuser (out_of_range)
//  cfg_     in         cfg_valid / cfg_ready cfg_index, cfg_data
//
// A score result is valid after three store reads and a capture per dimension and three
// passes per component; then the shared divide and square-root unit runs twice.
// Out-of-range ids skip these steps: the controller goes from its check to the output.
// Reset clears control state only; stores hold garbage until written.
// A finished result waits in the output register; the next item is taken meanwhile.
module knowledge_triple_scorer_top #(
    parameter int ENTITY_ROWS   = 1024,
    parameter int RELATION_ROWS = 256,
    parameter int DIM_MAX       = 64
) (
    input  logic         clk,
    input  logic         rst_n,
    input  logic         s_tvalid,
    output logic         s_tready,
    // row[9:0], element[15:10], value_real[31:16], value_i[47:32], value_j[63:48],
    // value_k[79:64], head[89:80], relation[97:90], tail[107:98], zero pad
    input  logic [111:0] s_tdata,
    input  logic [1:0]   s_tuser,   // op[1:0]
    output logic         m_tvalid,
    input  logic         m_tready,
    output logic [15:0]  m_tdata,   // score[15:0]
    output logic         m_tuser,   // out_of_range
    input  logic         cfg_valid,
    output logic         cfg_ready,
    input  logic [1:0]   cfg_index,
    input  logic [6:0]   cfg_data
);

    import kts_pkg::*;

    kts_cmd_t  cmd;
    kts_stat_t stat;

    kts_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tuser  (s_tuser),
        .stat     (stat),
        .cmd      (cmd)
    );

    kts_dp #(
        .ENTITY_ROWS   (ENTITY_ROWS),
        .RELATION_ROWS (RELATION_ROWS),
        .DIM_MAX       (DIM_MAX)
    ) u_dp (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .stat      (stat),
        .s_tvalid  (s_tvalid),
        .s_tdata   (s_tdata),
        .s_tuser   (s_tuser),
        .m_tvalid  (m_tvalid),
        .m_tready  (m_tready),
        .m_tdata   (m_tdata),
        .m_tuser   (m_tuser),
        .cfg_valid (cfg_valid),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    assign s_tready  = cmd.ready;
    assign cfg_ready = 1'b1;

endmodule

// ===== src/kts_checker.sv =====
// Port-level checks of the triple scorer, bound to the top level.
// Depends on kts_pkg and assert_macros.svh.
`include "assert_macros.svh"

module kts_checker (
    input logic        clk,
    input logic        rst_n,
    input logic        s_tvalid,
    input logic        s_tready,
    input logic [1:0]  s_tuser,
    input logic        m_tvalid,
    input logic        m_tready,
    input logic [15:0] m_tdata,
    input logic        m_tuser
);

    import kts_pkg::*;

    `KTS_ASSERT_NXT(a_out_hold, m_tvalid && !m_tready, m_tvalid)
    `KTS_ASSERT_NXT(a_out_stable, m_tvalid && !m_tready, $stable(m_tdata))
    `KTS_ASSERT_IMP(a_oor_max, m_tvalid && m_tuser, m_tdata == SCORE_MAX)
    `KTS_ASSERT_NXT(a_score_busy, s_tvalid && s_tready && s_tuser == OP_SCORE, !s_tready)

endmodule

bind knowledge_triple_scorer_top kts_checker u_kts_checker (.*);
